@@ hw/rtl/kuat_pkg.sv @@
// Shared types and constants for the keyed usage accumulation table.
// Holds the entry layout, operation and status codes, and the sequencer states.
// No dependencies.
package kuat_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int MODE_W   = 3;
  localparam int KEY_W    = 36;
  localparam int DATA_W   = 32;
  localparam int INDEX_W  = 8;
  localparam int STATUS_W = 2;
  localparam int USED_W   = 9;

  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd0;
  localparam logic [MODE_W-1:0] MODE_ADD   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LOAD  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SORT  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP   = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  name;
    logic [DATA_W-1:0] runs;
    logic [DATA_W-1:0] total;
  } entry_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH,
    ST_APPEND,
    ST_UPDATE,
    ST_SORT_LD,
    ST_SORT_CMP,
    ST_SORT_WR,
    ST_READ,
    ST_RESP
  } state_t;

endpackage

@@ hw/rtl/kuat_ram.sv @@
// Generic single-write, single-read memory with a registered read port.
// Used for the entry table. No dependencies.
module kuat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic                                    rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/keyed_usage_accumulation_table_top.sv @@
// Top level of the keyed usage accumulation table: sequencer, datapath and entry memory.
// Depends on kuat_pkg and kuat_ram.
//
// The block takes one word at a time and returns one result word for it; in_stall is
// high from acceptance until the result is loaded into the output register. All
// table reads go through the single read port of one memory. Clear, unused modes
// and out-of-range reads go straight to the response state, a read passes through
// ST_READ, an add or load visits the entries in the key search one per cycle (at
// most CAPACITY) before its append or update, and a sort does one compare per
// cycle. There is no clearing pass after reset.
module keyed_usage_accumulation_table_top #(
  parameter int CAPACITY = kuat_pkg::CAPACITY_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [kuat_pkg::MODE_W-1:0]    mode,
  input  logic [kuat_pkg::KEY_W-1:0]     key_name,
  input  logic [kuat_pkg::DATA_W-1:0]    run_time,
  input  logic [kuat_pkg::DATA_W-1:0]    load_count,
  input  logic [kuat_pkg::INDEX_W-1:0]   read_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [kuat_pkg::STATUS_W-1:0]  status,
  output logic [kuat_pkg::KEY_W-1:0]     entry_name,
  output logic [kuat_pkg::DATA_W-1:0]    entry_count,
  output logic [kuat_pkg::DATA_W-1:0]    entry_time,
  output logic [kuat_pkg::USED_W-1:0]    entries_used
);

  import kuat_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  state_t state, state_next;

  logic [MODE_W-1:0]   mode_q;
  logic [KEY_W-1:0]    key_q;
  logic [DATA_W-1:0]   rtime_q;
  logic [DATA_W-1:0]   lcount_q;
  logic [CW-1:0]       used;
  logic [CW-1:0]       i;
  logic [CW-1:0]       j;
  entry_t              cur;
  logic [STATUS_W-1:0] res_status;

  logic                rd_en;
  logic [IW-1:0]       rd_addr;
  entry_t              rd_data;
  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  entry_t              wr_data;

  logic                accept;
  logic                out_free;
  logic [CW:0]         used_ext;
  logic [CW:0]         i_inc;
  logic [CW:0]         i_inc2;
  logic [CW:0]         j_inc;
  logic                at_cap;
  logic                idx_ok;
  logic                match;
  logic                dup;
  logic                greater;
  logic [DATA_W:0]     runs_sum;
  logic [DATA_W:0]     total_sum;
  entry_t              upd_entry;

  kuat_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign used_ext  = {1'b0, used};
  assign i_inc     = {1'b0, i} + 1'b1;
  assign i_inc2    = i_inc + 1'b1;
  assign j_inc     = {1'b0, j} + 1'b1;
  assign at_cap    = (used == CW'(CAPACITY));
  assign idx_ok    = 32'(read_index) < 32'(used);
  assign match     = (rd_data.name == key_q);
  assign dup       = (mode_q == MODE_LOAD) && (cur.runs != '0);
  assign greater   = (rd_data.total > cur.total);
  assign runs_sum  = {1'b0, cur.runs} + 1'b1;
  assign total_sum = {1'b0, cur.total} + {1'b0, rtime_q};

  always_comb begin
    upd_entry.name = key_q;
    if (mode_q == MODE_ADD) begin
      upd_entry.runs  = runs_sum[DATA_W] ? '1 : runs_sum[DATA_W-1:0];
      upd_entry.total = total_sum[DATA_W] ? '1 : total_sum[DATA_W-1:0];
    end else begin
      upd_entry.runs  = lcount_q;
      upd_entry.total = rtime_q;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (mode) inside
            MODE_CLEAR: state_next = ST_RESP;
            MODE_ADD, MODE_LOAD: state_next = (used == '0) ? ST_APPEND : ST_SRCH;
            MODE_SORT: state_next = (used > CW'(1)) ? ST_SORT_LD : ST_RESP;
            MODE_READ: state_next = idx_ok ? ST_READ : ST_RESP;
            default: state_next = ST_RESP;
          endcase
        end
      end
      ST_SRCH: begin
        if (match) begin
          state_next = ST_UPDATE;
        end else if (j_inc >= used_ext) begin
          state_next = ST_APPEND;
        end
      end
      ST_APPEND:   state_next = at_cap ? ST_RESP : ST_UPDATE;
      ST_UPDATE:   state_next = ST_RESP;
      ST_SORT_LD:  state_next = ST_SORT_CMP;
      ST_SORT_CMP: state_next = (j_inc < used_ext) ? ST_SORT_CMP : ST_SORT_WR;
      ST_SORT_WR:  state_next = (i_inc2 < used_ext) ? ST_SORT_LD : ST_RESP;
      ST_READ:     state_next = ST_RESP;
      ST_RESP:     state_next = out_free ? ST_IDLE : ST_RESP;
      default:     state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != ST_IDLE);
    rd_en    = 1'b0;
    rd_addr  = '0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    wr_data  = cur;
    unique case (state)
      ST_IDLE: begin
        rd_en   = 1'b1;
        rd_addr = (mode == MODE_READ) ? IW'(read_index) : '0;
      end
      ST_SRCH: begin
        rd_en   = 1'b1;
        rd_addr = j_inc[IW-1:0];
      end
      ST_UPDATE: begin
        wr_en   = !dup;
        wr_addr = i[IW-1:0];
        wr_data = upd_entry;
      end
      ST_SORT_LD: begin
        rd_en   = 1'b1;
        rd_addr = i_inc[IW-1:0];
      end
      ST_SORT_CMP: begin
        rd_en   = 1'b1;
        rd_addr = j_inc[IW-1:0];
        wr_en   = greater;
        wr_addr = j[IW-1:0];
      end
      ST_SORT_WR: begin
        rd_en   = 1'b1;
        rd_addr = i_inc[IW-1:0];
        wr_en   = 1'b1;
        wr_addr = i[IW-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      used      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && accept && mode == MODE_CLEAR) begin
        used <= '0;
      end else if (state == ST_APPEND && !at_cap) begin
        used <= used + 1'b1;
      end
      if (state == ST_RESP && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          mode_q     <= mode;
          key_q      <= key_name;
          rtime_q    <= run_time;
          lcount_q   <= load_count;
          i          <= '0;
          j          <= '0;
          cur        <= '0;
          res_status <= (mode == MODE_READ && !idx_ok) ? STATUS_RANGE : STATUS_OK;
        end
      end
      ST_SRCH: begin
        if (match) begin
          cur <= rd_data;
          i   <= j;
        end else if (j_inc < used_ext) begin
          j <= j_inc[CW-1:0];
        end
      end
      ST_APPEND: begin
        cur.name  <= key_q;
        cur.runs  <= '0;
        cur.total <= '0;
        if (at_cap) begin
          res_status <= STATUS_FULL;
        end else begin
          i <= used;
        end
      end
      ST_UPDATE: begin
        if (dup) begin
          res_status <= STATUS_DUP;
        end else begin
          cur <= upd_entry;
        end
      end
      ST_SORT_LD: begin
        cur <= rd_data;
        j   <= i_inc[CW-1:0];
      end
      ST_SORT_CMP: begin
        if (greater) begin
          cur <= rd_data;
        end
        if (j_inc < used_ext) begin
          j <= j_inc[CW-1:0];
        end
      end
      ST_SORT_WR: begin
        i <= i_inc[CW-1:0];
        if (i_inc2 >= used_ext) begin
          cur <= '0;
        end
      end
      ST_READ: begin
        cur <= rd_data;
      end
      ST_RESP: begin
        if (out_free) begin
          status       <= res_status;
          entry_name   <= cur.name;
          entry_count  <= cur.runs;
          entry_time   <= cur.total;
          entries_used <= USED_W'(used);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hw/rtl/kuat_checker.sv @@
// Port-level checks for the keyed usage accumulation table, bound to its top level.
// Depends on kuat_pkg and keyed_usage_accumulation_table_top.
module kuat_checker #(
  parameter int CAPACITY = kuat_pkg::CAPACITY_DEF
) (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [kuat_pkg::STATUS_W-1:0]  status,
  input logic [kuat_pkg::KEY_W-1:0]     entry_name,
  input logic [kuat_pkg::DATA_W-1:0]    entry_count,
  input logic [kuat_pkg::DATA_W-1:0]    entry_time,
  input logic [kuat_pkg::USED_W-1:0]    entries_used
);

  import kuat_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(entry_name)
      && $stable(entry_count) && $stable(entry_time) && $stable(entries_used))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new word taken while the previous one is still in work");

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(entries_used) <= CAPACITY)
    else $error("occupied count beyond table capacity");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_FULL |-> entry_count == '0 && entry_time == '0)
    else $error("table-full result carries totals");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_RANGE
      |-> entry_name == '0 && entry_count == '0 && entry_time == '0)
    else $error("out-of-range read returns data");

endmodule

bind keyed_usage_accumulation_table_top kuat_checker #(.CAPACITY(CAPACITY)) u_checker (.*);
